### hw/rtl/dssq_pkg.sv
package dssq_pkg;

    localparam int unsigned TIME_W       = 64;
    localparam int unsigned ID_W         = 8;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned RESULT_LIMIT = 16;
    localparam int unsigned WOKE_W       = $clog2(RESULT_LIMIT + 1);

    localparam logic OP_SLEEP   = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WOKEN    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   task_id;
    } t_entry;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   woken_task;
        logic              last;
    } t_result;

endpackage

### hw/rtl/dssq_ifs.sv
interface dssq_item_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [dssq_pkg::ID_W-1:0]    task_id;
    logic [dssq_pkg::TIME_W-1:0]  duration;
    logic [dssq_pkg::TIME_W-1:0]  now;

    modport source (output valid, output operation, output task_id, output duration,
                    output now, input ready);
    modport sink (input valid, input operation, input task_id, input duration,
                  input now, output ready);
endinterface

interface dssq_result_if;
    logic                         valid;
    logic                         ready;
    logic [dssq_pkg::KIND_W-1:0]  kind;
    logic [dssq_pkg::ID_W-1:0]    woken_task;
    logic                         last;

    modport source (output valid, output kind, output woken_task, output last,
                    input ready);
    modport sink (input valid, input kind, input woken_task, input last,
                  output ready);
endinterface

### hw/rtl/dssq_mem.sv
module dssq_mem #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [$clog2(DEPTH)-1:0]           i_waddr,
    input  dssq_pkg::t_entry                   i_wdata,
    input  logic                               i_re,
    input  logic [$clog2(DEPTH)-1:0]           i_raddr,
    output dssq_pkg::t_entry                   o_rdata
);

    dssq_pkg::t_entry r_mem [DEPTH];
    dssq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/dssq_alu.sv
module dssq_alu (
    input  logic [dssq_pkg::TIME_W-1:0] i_sum_a,
    input  logic [dssq_pkg::TIME_W-1:0] i_sum_b,
    input  logic [dssq_pkg::TIME_W-1:0] i_cmp_a,
    input  logic [dssq_pkg::TIME_W-1:0] i_cmp_b,
    output logic [dssq_pkg::TIME_W-1:0] o_sum,
    output logic                        o_le
);

    logic [dssq_pkg::TIME_W:0] sum_full;

    // A carry out means the deadline lies beyond the clock range, so it sticks at the top.
    assign sum_full = {1'b0, i_sum_a} + {1'b0, i_sum_b};
    assign o_sum    = sum_full[dssq_pkg::TIME_W] ? {dssq_pkg::TIME_W{1'b1}}
                                                 : sum_full[dssq_pkg::TIME_W-1:0];
    assign o_le     = (i_cmp_a <= i_cmp_b);

endmodule

### hw/rtl/deadline_sorted_sleep_queue_unit.sv
// Channel   Direction  Beat carries
// i_item    in         operation, task_id, duration, now
// o_result  out        kind, woken_task, last
//
// A sleep walks down from the tail, moving each queued entry with a later deadline one place
// back, and is written behind the first entry whose deadline is not later than its own.
// A sleep into a full queue is refused with a full result and leaves the queue unchanged.
// A refresh wakes due tasks from the head, up to the result limit, one beat per task, else none.
// Reset is synchronous and empties the queue; entry contents are not cleared.
// A stalled result holds the sequencer only when a further beat must be issued.
module deadline_sorted_sleep_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dssq_item_if.sink             i_item,
    dssq_result_if.source         o_result
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_S_ADD = 3'd1;
    localparam logic [2:0] ST_S_RD  = 3'd2;
    localparam logic [2:0] ST_S_CMP = 3'd3;
    localparam logic [2:0] ST_S_FIN = 3'd4;
    localparam logic [2:0] ST_R_RD  = 3'd5;
    localparam logic [2:0] ST_R_CMP = 3'd6;

    logic [2:0]                          r_state,     n_state;
    logic [dssq_pkg::ID_W-1:0]           r_id,        n_id;
    logic [dssq_pkg::TIME_W-1:0]         r_dl,        n_dl;
    logic [dssq_pkg::TIME_W-1:0]         r_now,       n_now;
    logic [AW-1:0]                       r_head,      n_head;
    logic [CW-1:0]                       r_count,     n_count;
    logic [CW-1:0]                       r_idx,       n_idx;
    logic [dssq_pkg::WOKE_W-1:0]         r_woke,      n_woke;
    logic                                r_have,      n_have;
    logic [dssq_pkg::ID_W-1:0]           r_pend_id,   n_pend_id;
    logic                                r_out_valid, n_out_valid;
    dssq_pkg::t_result                   r_out,       n_out;

    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    dssq_pkg::t_entry                    mem_wdata;
    logic                                mem_re;
    logic [AW-1:0]                       mem_raddr;
    dssq_pkg::t_entry                    mem_rdata;

    logic [dssq_pkg::TIME_W-1:0]         alu_sum;
    logic [dssq_pkg::TIME_W-1:0]         alu_cmp_b;
    logic                                alu_le;
    logic                                out_free;
    logic                                refresh_done;

    function automatic logic [AW-1:0] f_phys(input logic [CW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, r_head} + (AW + 1)'(l);
        if (s >= (AW + 1)'(QUEUE_DEPTH)) begin
            s = s - (AW + 1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    dssq_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign alu_cmp_b = (r_state == ST_R_CMP) ? r_now : r_dl;

    dssq_alu u_alu (
        .i_sum_a (r_now),
        .i_sum_b (r_dl),
        .i_cmp_a (mem_rdata.deadline),
        .i_cmp_b (alu_cmp_b),
        .o_sum   (alu_sum),
        .o_le    (alu_le)
    );

    assign out_free     = !r_out_valid || o_result.ready;
    assign refresh_done = (r_count == '0) || (r_woke == dssq_pkg::WOKE_W'(dssq_pkg::RESULT_LIMIT));

    assign i_item.ready      = (r_state == ST_IDLE);
    assign o_result.valid      = r_out_valid;
    assign o_result.kind       = r_out.kind;
    assign o_result.woken_task = r_out.woken_task;
    assign o_result.last       = r_out.last;

    always_comb begin
        n_state     = r_state;
        n_id        = r_id;
        n_dl        = r_dl;
        n_now       = r_now;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_woke      = r_woke;
        n_have      = r_have;
        n_pend_id   = r_pend_id;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = f_phys(r_idx);
        mem_wdata   = '{deadline: r_dl, task_id: r_id};
        mem_raddr   = (r_state == ST_R_RD) ? r_head : f_phys(r_idx - CW'(1));

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_id    = i_item.task_id;
                    n_dl    = i_item.duration;
                    n_now   = i_item.now;
                    n_woke  = '0;
                    n_have  = 1'b0;
                    n_state = (i_item.operation == dssq_pkg::OP_SLEEP) ? ST_S_ADD : ST_R_RD;
                end
            end
            ST_S_ADD: begin
                if (r_count == CW'(QUEUE_DEPTH)) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{kind: dssq_pkg::KIND_FULL, woken_task: '0, last: 1'b1};
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_dl    = alu_sum;
                    n_idx   = r_count;
                    n_state = ST_S_RD;
                end
            end
            ST_S_RD: begin
                if (r_idx == '0) begin
                    mem_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = ST_S_FIN;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_S_CMP;
                end
            end
            ST_S_CMP: begin
                mem_we = 1'b1;
                if (!alu_le) begin
                    mem_wdata = mem_rdata;
                    n_idx     = r_idx - CW'(1);
                    n_state   = ST_S_RD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = ST_S_FIN;
                end
            end
            ST_S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: dssq_pkg::KIND_ACCEPTED, woken_task: '0, last: 1'b1};
                    n_state     = ST_IDLE;
                end
            end
            ST_R_RD: begin
                if (refresh_done) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out = r_have
                            ? dssq_pkg::t_result'{kind: dssq_pkg::KIND_WOKEN,
                                                  woken_task: r_pend_id, last: 1'b1}
                            : dssq_pkg::t_result'{kind: dssq_pkg::KIND_NONE,
                                                  woken_task: '0, last: 1'b1};
                        n_state = ST_IDLE;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_R_CMP;
                end
            end
            ST_R_CMP: begin
                if (alu_le) begin
                    if (!r_have || out_free) begin
                        if (r_have) begin
                            n_out_valid = 1'b1;
                            n_out = '{kind: dssq_pkg::KIND_WOKEN, woken_task: r_pend_id,
                                      last: 1'b0};
                        end
                        n_pend_id = mem_rdata.task_id;
                        n_have    = 1'b1;
                        n_head    = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
                        n_count   = r_count - CW'(1);
                        n_woke    = r_woke + dssq_pkg::WOKE_W'(1);
                        n_state   = ST_R_RD;
                    end
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = r_have
                        ? dssq_pkg::t_result'{kind: dssq_pkg::KIND_WOKEN,
                                              woken_task: r_pend_id, last: 1'b1}
                        : dssq_pkg::t_result'{kind: dssq_pkg::KIND_NONE,
                                              woken_task: '0, last: 1'b1};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_woke      <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_woke      <= n_woke;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
        r_id      <= n_id;
        r_dl      <= n_dl;
        r_now     <= n_now;
        r_pend_id <= n_pend_id;
        r_out     <= n_out;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_write_in_sleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_S_RD || r_state == ST_S_CMP))
        else $error("Entry memory written outside an insertion.");

    a_woke_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_woke <= dssq_pkg::WOKE_W'(dssq_pkg::RESULT_LIMIT))
        else $error("Wake count exceeds the result limit.");

    a_pending_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_R_RD && r_woke != '0) |-> r_have)
        else $error("Woken task lost before its result was issued.");
`endif

endmodule

### verif/dssq_result_checker.sv
`timescale 1ns / 100ps

module dssq_result_checker #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    dssq_item_if   i_item,
    dssq_result_if i_result,
    output int     o_mismatches,
    output int     o_outstanding
);

    logic [dssq_pkg::TIME_W-1:0] wake_at [QUEUE_DEPTH];
    logic [dssq_pkg::ID_W-1:0]   sleeper [QUEUE_DEPTH];
    int                          held;
    dssq_pkg::t_result           awaited [$];
    int                          mismatches;
    int                          result_beats;

    function automatic dssq_pkg::t_result make_result(logic [dssq_pkg::KIND_W-1:0] kind,
                                                      logic [dssq_pkg::ID_W-1:0] id,
                                                      logic last);
        dssq_pkg::t_result res;
        res.kind       = kind;
        res.woken_task = id;
        res.last       = last;
        return res;
    endfunction

    function automatic void queue_sleeper(logic [dssq_pkg::ID_W-1:0] id,
                                          logic [dssq_pkg::TIME_W-1:0] span,
                                          logic [dssq_pkg::TIME_W-1:0] stamp);
        logic [dssq_pkg::TIME_W:0]   sum;
        logic [dssq_pkg::TIME_W-1:0] deadline;
        int                          slot;
        int                          i;
        sum      = {1'b0, stamp} + {1'b0, span};
        deadline = sum[dssq_pkg::TIME_W] ? '1 : sum[dssq_pkg::TIME_W-1:0];
        if (held >= QUEUE_DEPTH) begin
            awaited.push_back(make_result(dssq_pkg::KIND_FULL, '0, 1'b1));
            return;
        end
        slot = 0;
        while (slot < held && wake_at[slot] <= deadline) begin
            slot++;
        end
        for (i = held; i > slot; i--) begin
            wake_at[i] = wake_at[i-1];
            sleeper[i] = sleeper[i-1];
        end
        wake_at[slot] = deadline;
        sleeper[slot] = id;
        held++;
        awaited.push_back(make_result(dssq_pkg::KIND_ACCEPTED, '0, 1'b1));
    endfunction

    function automatic void wake_due(logic [dssq_pkg::TIME_W-1:0] stamp);
        int due;
        int i;
        due = 0;
        while (due < held && due < dssq_pkg::RESULT_LIMIT && wake_at[due] <= stamp) begin
            due++;
        end
        if (due == 0) begin
            awaited.push_back(make_result(dssq_pkg::KIND_NONE, '0, 1'b1));
            return;
        end
        for (i = 0; i < due; i++) begin
            awaited.push_back(make_result(dssq_pkg::KIND_WOKEN, sleeper[i], i == due - 1));
        end
        for (i = due; i < held; i++) begin
            wake_at[i-due] = wake_at[i];
            sleeper[i-due] = sleeper[i];
        end
        held -= due;
    endfunction

    function automatic void flag_mismatch(logic unexpected, dssq_pkg::t_result want,
                                          dssq_pkg::t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            if (unexpected) begin
                $display("result beat %0d: none awaited, got kind %0d task %0d last %0d",
                         result_beats, got.kind, got.woken_task, got.last);
            end else begin
                $display("beat %0d: exp kind %0d id %0d last %0d, got kind %0d id %0d last %0d",
                         result_beats, want.kind, want.woken_task, want.last,
                         got.kind, got.woken_task, got.last);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        dssq_pkg::t_result got;
        dssq_pkg::t_result want;
        if (!i_rst_n) begin
            held         = 0;
            mismatches   = 0;
            result_beats = 0;
            awaited.delete();
        end else begin
            if (i_item.valid && i_item.ready) begin
                if (i_item.operation == dssq_pkg::OP_SLEEP) begin
                    queue_sleeper(i_item.task_id, i_item.duration, i_item.now);
                end else begin
                    wake_due(i_item.now);
                end
            end
            if (i_result.valid && i_result.ready) begin
                got.kind       = i_result.kind;
                got.woken_task = i_result.woken_task;
                got.last       = i_result.last;
                if (awaited.size() == 0) begin
                    flag_mismatch(1'b1, got, got);
                end else begin
                    want = awaited.pop_front();
                    if (got.kind !== want.kind || got.woken_task !== want.woken_task ||
                        got.last !== want.last) begin
                        flag_mismatch(1'b0, want, got);
                    end
                end
                result_beats++;
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= awaited.size();
    end

endmodule

### verif/deadline_sorted_sleep_queue_unit_test.sv
`timescale 1ns / 100ps

module deadline_sorted_sleep_queue_unit_test;

    localparam int unsigned QUEUE_DEPTH  = 16;
    localparam int          RANDOM_ITEMS = 83;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   burst_left;
    int   rx_cycle;
    int   rx_mode;

    dssq_item_if   item_bus ();
    dssq_result_if result_bus ();

    deadline_sorted_sleep_queue_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    dssq_result_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_item        (item_bus),
        .i_result      (result_bus),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial clk = 1'b0;

    always begin
        #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("deadline_sorted_sleep_queue_unit: mismatch");
        $finish;
    end

    initial begin
        result_bus.ready <= 1'b0;
        rx_cycle = 0;
        rx_mode  = 0;
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle % 64 == 0) begin
                rx_mode = $urandom_range(0, 3);
            end
            case (rx_mode)
                0: begin
                    result_bus.ready <= 1'b1;
                end
                1: begin
                    result_bus.ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    result_bus.ready <= (rx_cycle % 4 == 0);
                end
                default: begin
                    result_bus.ready <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    function automatic logic [dssq_pkg::TIME_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(logic op, logic [dssq_pkg::ID_W-1:0] id,
                             logic [dssq_pkg::TIME_W-1:0] span,
                             logic [dssq_pkg::TIME_W-1:0] stamp);
        if (burst_left == 0) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 8);
        end
        item_bus.valid     <= 1'b1;
        item_bus.operation <= op;
        item_bus.task_id   <= id;
        item_bus.duration  <= span;
        item_bus.now       <= stamp;
        do begin
            @(posedge clk);
        end while (item_bus.ready !== 1'b1);
        burst_left--;
    endtask

    initial begin
        int                          pick;
        int                          sleep_pct;
        logic [dssq_pkg::ID_W-1:0]   id;
        logic [dssq_pkg::TIME_W-1:0] span;
        logic [dssq_pkg::TIME_W-1:0] stamp;
        logic [dssq_pkg::TIME_W-1:0] cur_time;

        burst_left          = 0;
        rst_n              <= 1'b0;
        item_bus.valid     <= 1'b0;
        item_bus.operation <= dssq_pkg::OP_SLEEP;
        item_bus.task_id   <= '0;
        item_bus.duration  <= '0;
        item_bus.now       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(dssq_pkg::OP_REFRESH, 8'h00, '0, '0);
        send_item(dssq_pkg::OP_SLEEP, 8'h00, 64'd50, '0);
        send_item(dssq_pkg::OP_SLEEP, 8'hFF, 64'd10, '0);
        send_item(dssq_pkg::OP_SLEEP, 8'h5A, '0, '0);
        send_item(dssq_pkg::OP_SLEEP, 8'hA5, 64'd50, '0);
        send_item(dssq_pkg::OP_SLEEP, 8'hA5, 64'd40, 64'd10);
        send_item(dssq_pkg::OP_SLEEP, 8'h01, '1, '1);
        send_item(dssq_pkg::OP_SLEEP, 8'h02, 64'd1, '1);
        send_item(dssq_pkg::OP_SLEEP, 8'h04, '1, '0);
        send_item(dssq_pkg::OP_REFRESH, 8'hFF, '1, 64'd9);
        send_item(dssq_pkg::OP_REFRESH, 8'h00, '0, 64'd50);
        for (int k = 0; k < 13; k++) begin
            send_item(dssq_pkg::OP_SLEEP, 8'(16 + k), 64'(k), 64'd1000);
        end
        send_item(dssq_pkg::OP_SLEEP, 8'h77, '0, 64'd1000);
        send_item(dssq_pkg::OP_REFRESH, 8'h00, '0, '1);
        send_item(dssq_pkg::OP_REFRESH, 8'h00, '0, '1);

        cur_time = 64'd1000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sleep_pct = ((n / 20) % 2 == 0) ? 80 : 35;
            if ($urandom_range(0, 99) < sleep_pct) begin
                id   = ($urandom_range(0, 99) < 20) ? dssq_pkg::ID_W'($urandom_range(0, 3))
                                                    : dssq_pkg::ID_W'($urandom_range(0, 255));
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    span = dssq_pkg::TIME_W'($urandom_range(0, 40));
                end else if (pick < 75) begin
                    span = dssq_pkg::TIME_W'(10 * $urandom_range(0, 2));
                end else if (pick < 88) begin
                    span = rand_word();
                end else begin
                    span = '1 - dssq_pkg::TIME_W'($urandom_range(0, 3));
                end
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    stamp = cur_time;
                end else if (pick < 90) begin
                    stamp = rand_word();
                end else begin
                    stamp = cur_time - dssq_pkg::TIME_W'($urandom_range(0, 20));
                end
                send_item(dssq_pkg::OP_SLEEP, id, span, stamp);
            end else begin
                cur_time += dssq_pkg::TIME_W'($urandom_range(0, 30));
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    stamp = cur_time;
                end else if (pick < 92) begin
                    stamp = '1;
                end else begin
                    stamp = rand_word();
                end
                send_item(dssq_pkg::OP_REFRESH, dssq_pkg::ID_W'($urandom_range(0, 255)),
                          rand_word(), stamp);
            end
        end
        item_bus.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (2 * QUEUE_DEPTH + 16) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("deadline_sorted_sleep_queue_unit: match");
        end else begin
            $display("deadline_sorted_sleep_queue_unit: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/dssq_pkg.sv
hw/rtl/dssq_ifs.sv
hw/rtl/dssq_mem.sv
hw/rtl/dssq_alu.sv
hw/rtl/deadline_sorted_sleep_queue_unit.sv
verif/dssq_result_checker.sv
verif/deadline_sorted_sleep_queue_unit_test.sv
